FILE: hdl/kst_pkg.sv
package kst_pkg;

    localparam int OPCODE_W = 2;
    localparam int SLOT_W   = 6;
    localparam int KEY_W    = 64;
    localparam int COUNT_W  = 7;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SLOT_W-1:0]   slot_index;
        logic [KEY_W-1:0]    key_value;
    } kst_req_t;

    typedef struct packed {
        logic                success;
        logic [SLOT_W-1:0]   found_slot;
        logic [KEY_W-1:0]    slot_key;
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  free_count;
    } kst_rsp_t;

endpackage

FILE: hdl/keyed_slot_table.sv
// path from accept to result valid: insert, unused opcode and free-slot query pass EXEC then OUT,
// occupied-slot query adds QWAIT for the key read, remove scans from slot 0 until a match or the last slot
// throughput: one request at a time, the next is taken once the result is in the
// output register; remove is set by the key ram scan, one slot read per cycle
// reset: synchronous active low, clears occupied marks, count and handshake state;
// keys are not cleared, no clearing pass
module keyed_slot_table
    import kst_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  kst_req_t s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output kst_rsp_t m_payload
);

    localparam int KEY_BITS = 8 * KEY_BYTES;
    localparam int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW       = $clog2(SLOTS + 1);
    localparam int SXW      = IW + SLOT_W;
    localparam logic [IW-1:0] LAST      = IW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QWAIT,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    kst_req_t              req_reg, req_next;
    logic [SLOTS-1:0]      used_reg, used_next;
    logic [CW-1:0]         total_reg, total_next;
    logic                  ok_reg, ok_next;
    logic [SLOT_W-1:0]     where_reg, where_next;
    logic [KEY_W-1:0]      rkey_reg, rkey_next;
    logic [IW-1:0]         rd_idx_reg, rd_idx_next;
    logic [IW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  m_valid_reg, m_valid_next;
    kst_rsp_t              m_payload_reg, m_payload_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [KEY_BITS-1:0]   ram_rdata;
    logic [KEY_BITS-1:0]   req_key;
    logic [SXW-1:0]        slot_ext;
    logic [IW-1:0]         slot_addr;
    logic                  slot_ok;

    assign req_key   = req_reg.key_value[KEY_BITS-1:0];
    assign slot_ext  = SXW'(req_reg.slot_index);
    assign slot_addr = slot_ext[IW-1:0];
    assign slot_ok   = 32'(req_reg.slot_index) < SLOTS;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    kst_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_addr),
        .wr_data (req_key),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        ok_next        = ok_reg;
        where_next     = where_reg;
        rkey_next      = rkey_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_payload;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ok_next    = 1'b0;
                where_next = req_reg.slot_index;
                rkey_next  = '0;
                state_next = ST_OUT;
                case (req_reg.opcode)
                    OP_INSERT: begin
                        if (slot_ok && !used_reg[slot_addr]) begin
                            ram_we               = 1'b1;
                            used_next[slot_addr] = 1'b1;
                            total_next           = total_reg + 1'b1;
                            ok_next              = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        where_next     = '0;
                        rd_idx_next    = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    OP_QUERY: begin
                        if (slot_ok && used_reg[slot_addr]) begin
                            ram_re     = 1'b1;
                            ram_raddr  = slot_addr;
                            ok_next    = 1'b1;
                            state_next = ST_QWAIT;
                        end
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_QWAIT: begin
                rkey_next  = KEY_W'(ram_rdata);
                state_next = ST_OUT;
            end
            ST_SCAN: begin
                // read slot rd_idx while comparing the slot read last cycle
                ram_re         = 1'b1;
                ram_raddr      = rd_idx_reg;
                rd_idx_next    = (rd_idx_reg == LAST) ? '0 : rd_idx_reg + 1'b1;
                cmp_idx_next   = rd_idx_reg;
                cmp_valid_next = 1'b1;
                if (cmp_valid_reg && used_reg[cmp_idx_reg] && ram_rdata == req_key) begin
                    used_next[cmp_idx_reg] = 1'b0;
                    total_next             = total_reg - 1'b1;
                    ok_next                = 1'b1;
                    where_next             = SLOT_W'(cmp_idx_reg);
                    state_next             = ST_OUT;
                end else if (cmp_valid_reg && cmp_idx_reg == LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.success    = ok_reg;
                    m_payload_next.found_slot = where_reg;
                    m_payload_next.slot_key   = rkey_reg;
                    m_payload_next.used_count = COUNT_W'(total_reg);
                    m_payload_next.free_count = COUNT_W'(SLOTS_CNT - total_reg);
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            total_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            total_reg     <= total_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        req_reg       <= req_next;
        ok_reg        <= ok_next;
        where_reg     <= where_next;
        rkey_reg      <= rkey_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

FILE: hdl/kst_ram.sv
module kst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/kst_checker.sv
module kst_checker
    import kst_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input kst_req_t s_payload,
    input logic     m_valid,
    input logic     m_ready,
    input kst_rsp_t m_payload
);

    localparam logic [COUNT_W-1:0] SLOTS_MOD = COUNT_W'(SLOTS);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // counts always add up to the table size
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> COUNT_W'(m_payload.used_count + m_payload.free_count) == SLOTS_MOD)
        else $error("used and free counts disagree with table size");

    // a nonzero key only comes back from a successful query
    a_key_success: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.slot_key != '0 |-> m_payload.success)
        else $error("key returned without success");

    // one request at a time: busy right after an accept
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

endmodule

bind keyed_slot_table kst_checker #(.SLOTS(SLOTS)) u_kst_checker (.*);
